>>> hw/rtl/vzc_pkg.sv
// ----------------------------------------------------------------------------
// vzc_pkg: shared types and constants of the varint / zigzag codec
// Group width, byte limits, state codes and control structs.
// ----------------------------------------------------------------------------
package vzc_pkg;

  localparam int unsigned VALUE_W   = 64;
  localparam int unsigned GROUP_W   = 7;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned MAX_WIDE  = 10;
  localparam int unsigned MAX_NARR  = 5;
  // Decode gathers groups at the top of a register holding ten groups.
  localparam int unsigned ACC_W     = GROUP_W * MAX_WIDE;

  localparam logic [VALUE_W-1:0] MASK_NARROW = 64'h0000_0000_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] MASK_WIDE   = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_VALUE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ENC,
    ST_ALIGN
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
  } enc_ctl_t;

  typedef struct packed {
    logic                more;
    logic [BYTE_W-1:0]   data;
  } enc_stat_t;

endpackage

>>> hw/rtl/vzc_if.sv
// ----------------------------------------------------------------------------
// vzc_in_if / vzc_out_if: valid/ready channels of the codec
// Input carries one request beat, output carries one result beat.
// ----------------------------------------------------------------------------
interface vzc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic                         is_signed;
  logic                         is_wide;
  logic [vzc_pkg::VALUE_W-1:0]  value_in;
  logic [vzc_pkg::BYTE_W-1:0]   byte_in;

  modport source (output valid, mode, is_signed, is_wide, value_in, byte_in,
                  input ready);
  modport sink   (input valid, mode, is_signed, is_wide, value_in, byte_in,
                  output ready);
endinterface

interface vzc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [vzc_pkg::BYTE_W-1:0]   byte_out;
  logic [vzc_pkg::VALUE_W-1:0]  value_out;
  logic                         last;

  modport source (output valid, kind, byte_out, value_out, last, input ready);
  modport sink   (input valid, kind, byte_out, value_out, last, output ready);
endinterface

>>> hw/rtl/vzc_enc_shifter.sv
// ----------------------------------------------------------------------------
// vzc_enc_shifter: encode shift register
// Holds the mapped value and releases one seven-bit group per shift.
// ----------------------------------------------------------------------------
module vzc_enc_shifter (
  input  logic                        clk,
  input  logic                        rst,
  input  vzc_pkg::enc_ctl_t           ctl,
  input  logic [vzc_pkg::VALUE_W-1:0] load_value,
  output vzc_pkg::enc_stat_t          stat
);

  logic [vzc_pkg::VALUE_W-1:0] sh;
  logic [vzc_pkg::CNT_W-1:0]   n;

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
    end else if (ctl.load) begin
      n <= '0;
    end else if (ctl.shift) begin
      n <= n + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sh <= load_value;
    end else if (ctl.shift) begin
      sh <= {{vzc_pkg::GROUP_W{1'b0}}, sh[vzc_pkg::VALUE_W-1:vzc_pkg::GROUP_W]};
    end
  end

  // The tenth byte always ends the varint, whatever is left above it.
  always_comb begin
    stat.more = (sh[vzc_pkg::VALUE_W-1:vzc_pkg::GROUP_W] != '0) &&
                (n < vzc_pkg::CNT_W'(vzc_pkg::MAX_WIDE - 1));
    stat.data = stat.more ? {1'b1, sh[vzc_pkg::GROUP_W-1:0]}
                          : sh[vzc_pkg::BYTE_W-1:0];
  end

endmodule

>>> hw/rtl/varint_zigzag_codec.sv
// ----------------------------------------------------------------------------
// varint_zigzag_codec: base-128 varint encoder / decoder with zigzag mapping
// Top level: request handling, decode accumulator and result register.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on in_ch, results leave on out_ch; both are valid/ready
// channels and a beat moves when valid and ready are high at a clock edge.
// An encode request (mode 0) yields 1 to 10 byte beats, one per cycle while
// the receiver takes them, the final one flagged by last. The request is
// loaded into the encode shift register, each byte then passes through the
// output register, and no new request is taken until the last byte is issued.
// A decode request (mode 1) carries one byte; nothing is returned until the
// byte that ends the value. That byte then starts an alignment walk of
// 10 - k steps (k = bytes gathered) that slides the gathered groups down
// seven bits a cycle, and the value beat follows. The worst case per item is
// set by the seven-bit group shifters of the encoder and the decode accumulator.
// A result waits in the output register while the receiver stalls; the
// block keeps taking decode bytes that end no value meanwhile, and holds
// off further results until the register is taken.
// Synchronous reset empties the output register, returns to idle and
// clears any partially gathered decode value.
// ----------------------------------------------------------------------------
module varint_zigzag_codec (
  input  logic        clk,
  input  logic        rst,
  vzc_in_if.sink      in_ch,
  vzc_out_if.source   out_ch
);

  vzc_pkg::state_t state;
  vzc_pkg::state_t state_next;

  // Decode accumulator: each new group enters at the top and older groups
  // slide down, so after k bytes group j sits at bit 7*(10-k+j).
  logic [vzc_pkg::ACC_W-1:0]   acc;
  logic [vzc_pkg::CNT_W-1:0]   cnt;
  logic [vzc_pkg::CNT_W-1:0]   rem;
  logic                        dec_signed;
  logic                        dec_wide;

  // Result register.
  logic                        o_valid;
  logic                        o_kind;
  logic [vzc_pkg::BYTE_W-1:0]  o_byte;
  logic [vzc_pkg::VALUE_W-1:0] o_value;
  logic                        o_last;

  vzc_pkg::enc_ctl_t           enc_ctl;
  vzc_pkg::enc_stat_t          enc_stat;
  logic [vzc_pkg::VALUE_W-1:0] enc_value;

  logic                        accept;
  logic                        out_free;
  logic [vzc_pkg::CNT_W-1:0]   cnt_inc;
  logic                        dec_final;
  logic [vzc_pkg::VALUE_W-1:0] in_mask;
  logic [vzc_pkg::VALUE_W-1:0] enc_masked;
  logic                        enc_top;
  logic [vzc_pkg::VALUE_W-1:0] dec_mask;
  logic [vzc_pkg::VALUE_W-1:0] dec_raw;
  logic [vzc_pkg::VALUE_W-1:0] dec_value;
  logic                        emit_byte;
  logic                        emit_value;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !o_valid || out_ch.ready;

  // Zigzag on encode: (n << 1) ^ (n >> (W-1)), kept within the width.
  assign in_mask    = in_ch.is_wide ? vzc_pkg::MASK_WIDE : vzc_pkg::MASK_NARROW;
  assign enc_masked = in_ch.value_in & in_mask;
  assign enc_top    = in_ch.is_wide ? enc_masked[vzc_pkg::VALUE_W-1]
                                    : enc_masked[vzc_pkg::VALUE_W/2-1];
  assign enc_value  = in_ch.is_signed
                      ? (({enc_masked[vzc_pkg::VALUE_W-2:0], 1'b0}
                          ^ (enc_top ? in_mask : '0)) & in_mask)
                      : enc_masked;

  // A byte below 0x80 ends the value, as does reaching the width's limit.
  assign cnt_inc   = cnt + 1'b1;
  assign dec_final = !in_ch.byte_in[vzc_pkg::BYTE_W-1] ||
                     (cnt_inc >= (in_ch.is_wide ? vzc_pkg::CNT_W'(vzc_pkg::MAX_WIDE)
                                                : vzc_pkg::CNT_W'(vzc_pkg::MAX_NARR)));

  // Zigzag on decode: (u >> 1) ^ -(u & 1), within the width.
  assign dec_mask  = dec_wide ? vzc_pkg::MASK_WIDE : vzc_pkg::MASK_NARROW;
  assign dec_raw   = acc[vzc_pkg::VALUE_W-1:0] & dec_mask;
  assign dec_value = dec_signed
                     ? (({1'b0, dec_raw[vzc_pkg::VALUE_W-1:1]}
                         ^ {vzc_pkg::VALUE_W{dec_raw[0]}}) & dec_mask)
                     : dec_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vzc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ch.ready   = 1'b0;
    enc_ctl.load  = 1'b0;
    enc_ctl.shift = 1'b0;
    emit_byte     = 1'b0;
    emit_value    = 1'b0;
    case (state)
      vzc_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (accept) begin
          if (in_ch.mode == vzc_pkg::MODE_ENCODE) begin
            enc_ctl.load = 1'b1;
            state_next   = vzc_pkg::ST_ENC;
          end else if (dec_final) begin
            state_next = vzc_pkg::ST_ALIGN;
          end
        end
      end
      vzc_pkg::ST_ENC: begin
        if (out_free) begin
          emit_byte     = 1'b1;
          enc_ctl.shift = 1'b1;
          if (!enc_stat.more) begin
            state_next = vzc_pkg::ST_IDLE;
          end
        end
      end
      vzc_pkg::ST_ALIGN: begin
        if (rem == '0 && out_free) begin
          emit_value = 1'b1;
          state_next = vzc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = vzc_pkg::ST_IDLE;
      end
    endcase
  end

  vzc_enc_shifter u_enc (
    .clk        (clk),
    .rst        (rst),
    .ctl        (enc_ctl),
    .load_value (enc_value),
    .stat       (enc_stat)
  );

  // Decode state: count, alignment steps still to go, and the accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rem <= '0;
      acc <= '0;
    end else if (accept && in_ch.mode == vzc_pkg::MODE_DECODE) begin
      acc <= {in_ch.byte_in[vzc_pkg::GROUP_W-1:0], acc[vzc_pkg::ACC_W-1:vzc_pkg::GROUP_W]};
      cnt <= cnt_inc;
      rem <= vzc_pkg::CNT_W'(vzc_pkg::MAX_WIDE) - cnt_inc;
    end else if (state == vzc_pkg::ST_ALIGN) begin
      if (rem != '0) begin
        acc <= {{vzc_pkg::GROUP_W{1'b0}}, acc[vzc_pkg::ACC_W-1:vzc_pkg::GROUP_W]};
        rem <= rem - 1'b1;
      end else if (emit_value) begin
        acc <= '0;
        cnt <= '0;
      end
    end
  end

  // The flags of the byte that ends the value govern the final mapping.
  always_ff @(posedge clk) begin
    if (accept && in_ch.mode == vzc_pkg::MODE_DECODE) begin
      dec_signed <= in_ch.is_signed;
      dec_wide   <= in_ch.is_wide;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (emit_byte || emit_value) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_byte) begin
      o_kind  <= vzc_pkg::KIND_BYTE;
      o_byte  <= enc_stat.data;
      o_value <= '0;
      o_last  <= !enc_stat.more;
    end else if (emit_value) begin
      o_kind  <= vzc_pkg::KIND_VALUE;
      o_byte  <= '0;
      o_value <= dec_value;
      o_last  <= 1'b1;
    end
  end

  assign out_ch.valid     = o_valid;
  assign out_ch.kind      = o_kind;
  assign out_ch.byte_out  = o_byte;
  assign out_ch.value_out = o_value;
  assign out_ch.last      = o_last;

endmodule

>>> tb/tb_varint_zigzag_codec.sv
// ----------------------------------------------------------------------------
// tb_varint_zigzag_codec: self-checking testbench of the varint / zigzag codec
// Drives encode and decode requests and predicts every byte and value beat
// the codec must return. Beats are checked in order, field by field, under
// several mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_varint_zigzag_codec;

  // Longest stretch without any beat on either channel before the run is
  // declared hung. Random stalls add a geometric tail on top of the block's
  // own worst case per item.
  localparam int unsigned STALL_LIMIT  = 1000;
  // Cycles to keep watching after the last expected beat has arrived. This is
  // a bit more than the longest encode plus the longest alignment walk.
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned PHASE_ITEMS  = 48;
  localparam int unsigned REPORT_MAX   = 10;

  // One request beat as the sender drives it.
  typedef struct packed {
    logic                         mode;
    logic                         is_signed;
    logic                         is_wide;
    logic [vzc_pkg::VALUE_W-1:0]  value_in;
    logic [vzc_pkg::BYTE_W-1:0]   byte_in;
  } codec_req_t;

  // One result beat as the receiver sees it.
  typedef struct packed {
    logic                         kind;
    logic [vzc_pkg::BYTE_W-1:0]   byte_out;
    logic [vzc_pkg::VALUE_W-1:0]  value_out;
    logic                         last;
  } codec_res_t;

  logic clk = 1'b0;
  logic rst;

  vzc_in_if  in_ch ();
  vzc_out_if out_ch ();

  varint_zigzag_codec i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Results the codec still owes us, oldest first.
  codec_res_t  pending_results[$];

  // Our own copy of the decoder's partial value: the seven-bit groups gathered
  // so far and how many bytes they came from.
  logic [vzc_pkg::VALUE_W-1:0] dec_groups;
  logic [vzc_pkg::CNT_W-1:0]   dec_nbytes;

  int unsigned items_sent;
  int unsigned fail_count;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  function automatic void push_result(input logic kind,
                                      input logic [vzc_pkg::BYTE_W-1:0] b_out,
                                      input logic [vzc_pkg::VALUE_W-1:0] v_out,
                                      input logic lst);
    codec_res_t res;
    res.kind      = kind;
    res.byte_out  = b_out;
    res.value_out = v_out;
    res.last      = lst;
    pending_results.insert(pending_results.size(), res);
  endfunction

  // Works out the beats that one accepted request causes and queues them.
  function automatic void predict_results(input codec_req_t r);
    logic [vzc_pkg::VALUE_W-1:0] wmask;
    logic [vzc_pkg::VALUE_W-1:0] v;
    logic [vzc_pkg::VALUE_W-1:0] neg;
    int unsigned                 top;
    int unsigned                 n;
    int unsigned                 lim;
    int unsigned                 c;

    wmask = r.is_wide ? vzc_pkg::MASK_WIDE : vzc_pkg::MASK_NARROW;
    if (r.mode == vzc_pkg::MODE_ENCODE) begin
      // In 32-bit mode the upper half of the value is simply ignored.
      v = r.value_in & wmask;
      if (r.is_signed) begin
        // Zigzag: shift left and flip everything when the sign bit is set.
        top = r.is_wide ? vzc_pkg::VALUE_W - 1 : vzc_pkg::VALUE_W / 2 - 1;
        neg = v[top] ? wmask : '0;
        v   = ((v << 1) ^ neg) & wmask;
      end
      n = 0;
      while (v >= 64'h80 && n < vzc_pkg::MAX_WIDE - 1) begin
        push_result(vzc_pkg::KIND_BYTE, {1'b1, v[vzc_pkg::GROUP_W-1:0]}, '0, 1'b0);
        v = v >> vzc_pkg::GROUP_W;
        n++;
      end
      push_result(vzc_pkg::KIND_BYTE, v[vzc_pkg::BYTE_W-1:0], '0, 1'b1);
    end else begin
      // Each byte obeys its own width: the limit comes from this byte's
      // is_wide even if earlier bytes of the value were sent with the other.
      c   = 32'(dec_nbytes);
      lim = r.is_wide ? vzc_pkg::MAX_WIDE : vzc_pkg::MAX_NARR;
      if (c > vzc_pkg::MAX_WIDE - 1) c = vzc_pkg::MAX_WIDE - 1;
      // Group bits that land above bit 63 fall off the end of the shift.
      dec_groups = dec_groups |
                   ({57'd0, r.byte_in[vzc_pkg::GROUP_W-1:0]} << (vzc_pkg::GROUP_W * c));
      c++;
      if (!r.byte_in[vzc_pkg::BYTE_W-1] || c >= lim) begin
        v = dec_groups & wmask;
        if (r.is_signed) v = ((v >> 1) ^ (64'd0 - {63'd0, v[0]})) & wmask;
        dec_groups = '0;
        dec_nbytes = '0;
        push_result(vzc_pkg::KIND_VALUE, '0, v, 1'b1);
      end else begin
        dec_nbytes = c[vzc_pkg::CNT_W-1:0];
      end
    end
  endfunction

  function automatic void note_failure(input string msg);
    if (fail_count < REPORT_MAX) $display("%s", msg);
    fail_count++;
  endfunction

  // Mostly full 64-bit patterns, often shifted down so that short encodings
  // and every byte count in between show up.
  function automatic logic [vzc_pkg::VALUE_W-1:0] random_value();
    logic [vzc_pkg::VALUE_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: v = v >> $urandom_range(0, 63);
      1: v = v >> $urandom_range(25, 63);
      default: ;
    endcase
    return v;
  endfunction

  // Sends one request beat, possibly after a random gap. The valid line is
  // only lowered when a gap is actually taken, so back-to-back beats keep it
  // high without a second assignment in the same time step.
  task automatic send_item(input codec_req_t r);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= r.mode;
    in_ch.is_signed <= r.is_signed;
    in_ch.is_wide   <= r.is_wide;
    in_ch.value_in  <= r.value_in;
    in_ch.byte_in   <= r.byte_in;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // The beat was taken at this edge; its results cannot appear before the
    // next one, so predicting here keeps the queue ahead of the receiver.
    predict_results(r);
    items_sent++;
  endtask

  task automatic send_encode(input logic sgn, input logic wide,
                             input logic [vzc_pkg::VALUE_W-1:0] v);
    codec_req_t r;
    r.mode      = vzc_pkg::MODE_ENCODE;
    r.is_signed = sgn;
    r.is_wide   = wide;
    r.value_in  = v;
    r.byte_in   = 8'($urandom_range(0, 255));
    send_item(r);
  endtask

  task automatic send_decode(input logic sgn, input logic wide,
                             input logic [vzc_pkg::BYTE_W-1:0] b);
    codec_req_t r;
    r.mode      = vzc_pkg::MODE_DECODE;
    r.is_signed = sgn;
    r.is_wide   = wide;
    r.value_in  = {$urandom, $urandom};
    r.byte_in   = b;
    send_item(r);
  endtask

  // Encode corners: zero, the largest value of each width, the one-byte /
  // two-byte boundary, stray upper bits in 32-bit mode and the zigzag
  // extremes including the most negative value of each width.
  task automatic test_encode_extremes();
    send_encode(1'b0, 1'b0, 64'h0);
    send_encode(1'b0, 1'b0, 64'hDEAD_BEEF_FFFF_FFFF);
    send_encode(1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_encode(1'b0, 1'b1, 64'h7F);
    send_encode(1'b0, 1'b1, 64'h80);
    send_encode(1'b1, 1'b0, 64'h0000_0000_8000_0000);
    send_encode(1'b1, 1'b1, 64'h8000_0000_0000_0000);
    send_encode(1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_encode(1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
  endtask

  // Decode corners: single-byte values, an overlong 32-bit value that is cut
  // off by the byte limit with bit 7 still set, and a value whose width
  // changes part way through with an encode slipped in between its bytes.
  task automatic test_decode_corners();
    send_decode(1'b0, 1'b0, 8'h00);
    send_decode(1'b1, 1'b1, 8'h7F);
    repeat (vzc_pkg::MAX_NARR) send_decode(1'b0, 1'b0, 8'hFF);
    send_decode(1'b0, 1'b1, 8'h81);
    send_decode(1'b0, 1'b1, 8'hFF);
    // The partial decode must survive this encode untouched.
    send_encode(1'b0, 1'b0, 64'd123);
    send_decode(1'b0, 1'b0, 8'h80);
    send_decode(1'b1, 1'b0, 8'hFF);
    send_decode(1'b1, 1'b0, 8'hFF);
  endtask

  // Random traffic under one idling mix: standalone encodes, varints of random
  // length with random payload bits and now and then an encode dropped in
  // mid-value, values that change width part way through, and lone random bytes.
  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    int unsigned                first;
    int unsigned                pick;
    int unsigned                len;
    int unsigned                lim;
    logic                       sgn;
    logic                       wide;
    logic [vzc_pkg::BYTE_W-1:0] b;

    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    first          = items_sent;
    while (items_sent - first < PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      sgn  = 1'($urandom_range(0, 1));
      wide = 1'($urandom_range(0, 1));
      if (pick < 40) begin
        send_encode(sgn, wide, random_value());
      end else if (pick < 85) begin
        // A varint of random length; now and then the final byte keeps bit 7 set,
        // so that only the byte limit, if the length reaches it, ends the value.
        lim = wide ? vzc_pkg::MAX_WIDE : vzc_pkg::MAX_NARR;
        len = $urandom_range(1, lim);
        for (int k = 0; k < len; k++) begin
          b    = 8'($urandom_range(0, 255));
          b[7] = (k != len - 1) || ($urandom_range(0, 3) == 0);
          if ($urandom_range(0, 9) == 0) send_encode(~sgn, wide, random_value());
          send_decode(sgn, wide, b);
        end
      end else if (pick < 93) begin
        // Start in 64-bit mode, finish in 32-bit mode: the narrow limit cuts
        // the value off once the total byte count reaches five.
        len = $urandom_range(1, vzc_pkg::MAX_NARR - 1);
        for (int k = 0; k < len; k++) begin
          send_decode(sgn, 1'b1, 8'h80 | 8'($urandom_range(0, 127)));
        end
        for (int k = len; k < vzc_pkg::MAX_NARR; k++) begin
          send_decode(sgn, 1'b0, 8'h80 | 8'($urandom_range(0, 127)));
        end
      end else begin
        send_decode(sgn, wide, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Receiver: checks every result beat against the oldest prediction and
  // picks a fresh ready for the next cycle.
  initial begin
    codec_res_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          note_failure($sformatf("unexpected beat: kind=%0d byte=%02h value=%016h last=%0d",
                                 out_ch.kind, out_ch.byte_out, out_ch.value_out, out_ch.last));
        end else begin
          want = pending_results.pop_front();
          if (out_ch.kind !== want.kind || out_ch.byte_out !== want.byte_out ||
              out_ch.value_out !== want.value_out || out_ch.last !== want.last) begin
            note_failure($sformatf({"mismatch: expected kind=%0d byte=%02h value=%016h ",
                                    "last=%0d, got kind=%0d byte=%02h value=%016h last=%0d"},
                                   want.kind, want.byte_out, want.value_out, want.last,
                                   out_ch.kind, out_ch.byte_out, out_ch.value_out,
                                   out_ch.last));
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: any beat on either channel counts as progress.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL varint_zigzag_codec");
        $finish;
      end
    end
  end

  initial begin
    dec_groups      = '0;
    dec_nbytes      = '0;
    items_sent      = 0;
    fail_count      = 0;
    quiet_cycles    = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= vzc_pkg::MODE_ENCODE;
    in_ch.is_signed <= 1'b0;
    in_ch.is_wide   <= 1'b0;
    in_ch.value_in  <= '0;
    in_ch.byte_in   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners run without gaps or stalls.
    test_encode_extremes();
    test_decode_corners();

    // Random phases: a clean stretch first, then gaps on each side alone,
    // then light gaps on both sides together.
    test_random_traffic(0, 0);
    test_random_traffic(57, 0);
    test_random_traffic(0, 57);
    test_random_traffic(19, 19);

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Stray beats after the last expected one would still be caught here.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS varint_zigzag_codec");
    end else begin
      $display("FAIL varint_zigzag_codec");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/vzc_pkg.sv
hw/rtl/vzc_if.sv
hw/rtl/vzc_enc_shifter.sv
hw/rtl/varint_zigzag_codec.sv
tb/tb_varint_zigzag_codec.sv
